/* hw/rtl/vno_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vno_pkg: shared constants, types and arithmetic helpers
// Stage payload structs, register indexes and the small modular multiply and
// bilinear blend helpers used by the value-noise octave pipeline.
// ----------------------------------------------------------------------------
package vno_pkg;

   // Frame and octave limits.
   localparam int X_SIZE     = 320;
   localparam int Y_SIZE     = 200;
   localparam int MAX_OCTAVE = 6;

   // Octave zero always adds zero, so only octaves 1..MAX_OCTAVE get a lane.
   // Lane j handles the lattice scale 2^(j+1).
   localparam int NUM_LANES = MAX_OCTAVE;

   // Only the low MAX_OCTAVE bits of any hash are ever kept, so all hash
   // arithmetic runs modulo 2^HB.
   localparam int HB = MAX_OCTAVE;

   // Field widths.
   localparam int PX_W       = 9;
   localparam int PY_W       = 8;
   localparam int BYTE_W     = 8;
   localparam int OCT_W      = 3;
   localparam int SEED_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = ((PX_W + PY_W + BYTE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BYTE_W + 7) / 8) * 8;

   // Hash constants reduced to the low HB bits.
   localparam logic [HB-1:0] HASH_MUL_LO = HB'(31337);
   localparam logic [HB-1:0] HASH_ADD_LO = HB'(3917);

   // Register reset values.
   localparam logic [OCT_W-1:0]  START_OCTAVE_RST = OCT_W'(6);
   localparam logic [SEED_W-1:0] HASH_SEED_RST    = SEED_W'(9);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_OCTAVE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_SEED    = 1'b1;

   // Register stages between the input and output transfers.
   localparam int PIPE_DEPTH = 6;
   localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

   // Input stage payload.
   typedef struct packed {
      logic [PX_W-1:0]      x;
      logic [PY_W-1:0]      y;
      logic [BYTE_W-1:0]    base;
      logic [NUM_LANES-1:0] lane_en;
   } pix_type;

   // Four lattice corners of one octave plus the fractional offsets.
   typedef struct packed {
      logic [HB-1:0] c00;
      logic [HB-1:0] c01;
      logic [HB-1:0] c10;
      logic [HB-1:0] c11;
      logic [HB-1:0] tx;
      logic [HB-1:0] ty;
   } corner_type;

   typedef struct packed {
      logic [BYTE_W-1:0]                base;
      logic [NUM_LANES-1:0]             lane_en;
      corner_type [NUM_LANES-1:0]       lane;
   } corner_set_type;

   // Two x-blended rows of one octave.
   typedef struct packed {
      logic [HB-1:0] row0;
      logic [HB-1:0] row1;
      logic [HB-1:0] ty;
   } row_type;

   typedef struct packed {
      logic [BYTE_W-1:0]          base;
      logic [NUM_LANES-1:0]       lane_en;
      row_type [NUM_LANES-1:0]    lane;
   } row_set_type;

   // Final per-octave noise values.
   typedef struct packed {
      logic [BYTE_W-1:0]              base;
      logic [NUM_LANES-1:0]           lane_en;
      logic [NUM_LANES-1:0][HB-1:0]   v;
   } noise_set_type;

   // Product modulo 2^HB.
   function automatic logic [HB-1:0] mul_mod(input logic [HB-1:0] a,
                                             input logic [HB-1:0] b);
      logic [2*HB-1:0] full;
      full = a * b;
      return full[HB-1:0];
   endfunction

   // a + (t*(b-a)) / 2^k with the quotient truncated toward zero.
   function automatic logic [HB-1:0] lerp(input logic [HB-1:0] a,
                                          input logic [HB-1:0] b,
                                          input logic [HB-1:0] t,
                                          input int            k);
      logic signed [HB+1:0]   diff;
      logic signed [2*HB+2:0] prod;
      logic [2*HB+2:0]        mag;
      logic [2*HB+2:0]        quo;
      logic [HB-1:0]          q_lo;
      diff = $signed({2'b00, b}) - $signed({2'b00, a});
      prod = $signed({{(HB+3){1'b0}}, t}) * diff;
      mag  = prod[2*HB+2] ? $unsigned(-prod) : $unsigned(prod);
      quo  = mag >> k;
      q_lo = quo[HB-1:0];
      if (prod[2*HB+2]) begin
         q_lo = ~q_lo + 1'b1;
      end
      return a + q_lo;
   endfunction

endpackage

/* hw/rtl/vno_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vno_hash: lattice corner hash, two register stages
// The first stage forms (cx+1)*cy for the four corners of every octave, the
// second multiplies by the premixed seed, adds the offset and masks to k bits.
// ----------------------------------------------------------------------------
module vno_hash
   import vno_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  pix_type        in_pix,
   input  logic [HB-1:0]  seed_mix,
   output logic           out_valid,
   input  logic           out_ready,
   output corner_set_type out_set
);

   logic           h1_valid_ff, h1_valid_in;
   corner_set_type h1_ff, h1_in;
   logic           h1_ready;
   logic           h2_valid_ff, h2_valid_in;
   corner_set_type h2_ff, h2_in;
   logic           h2_ready;

   // Each stage takes a new item when it is empty or drains this cycle.
   assign h2_ready = !h2_valid_ff || out_ready;
   assign h1_ready = !h1_valid_ff || h2_ready;
   assign in_ready = h1_ready;

   assign h1_valid_in = h1_ready ? in_valid : h1_valid_ff;
   assign h2_valid_in = h2_ready ? h1_valid_ff : h2_valid_ff;

   // Stage one: cell indexes, offsets and the (cx+1)*cy products.
   always_comb begin
      logic [PX_W-1:0] ix;
      logic [PY_W-1:0] iy;
      logic [HB-1:0]   mask;
      logic [HB-1:0]   cx1_lo, cx1_hi, cy_lo, cy_hi;
      h1_in.base    = in_pix.base;
      h1_in.lane_en = in_pix.lane_en;
      for (int j = 0; j < NUM_LANES; j++) begin
         ix     = in_pix.x >> (j + 1);
         iy     = in_pix.y >> (j + 1);
         mask   = HB'((1 << (j + 1)) - 1);
         cx1_lo = ix[HB-1:0] + HB'(1);
         cx1_hi = ix[HB-1:0] + HB'(2);
         cy_lo  = iy[HB-1:0];
         cy_hi  = iy[HB-1:0] + HB'(1);
         h1_in.lane[j].c00 = mul_mod(cx1_lo, cy_lo);
         h1_in.lane[j].c01 = mul_mod(cx1_lo, cy_hi);
         h1_in.lane[j].c10 = mul_mod(cx1_hi, cy_lo);
         h1_in.lane[j].c11 = mul_mod(cx1_hi, cy_hi);
         h1_in.lane[j].tx  = in_pix.x[HB-1:0] & mask;
         h1_in.lane[j].ty  = in_pix.y[HB-1:0] & mask;
      end
   end

   // Stage two: seed multiply, offset and mask to the octave's bit count.
   always_comb begin
      logic [HB-1:0] mask;
      h2_in.base    = h1_ff.base;
      h2_in.lane_en = h1_ff.lane_en;
      for (int j = 0; j < NUM_LANES; j++) begin
         mask = HB'((1 << (j + 1)) - 1);
         h2_in.lane[j].c00 = (mul_mod(h1_ff.lane[j].c00, seed_mix) + HASH_ADD_LO) & mask;
         h2_in.lane[j].c01 = (mul_mod(h1_ff.lane[j].c01, seed_mix) + HASH_ADD_LO) & mask;
         h2_in.lane[j].c10 = (mul_mod(h1_ff.lane[j].c10, seed_mix) + HASH_ADD_LO) & mask;
         h2_in.lane[j].c11 = (mul_mod(h1_ff.lane[j].c11, seed_mix) + HASH_ADD_LO) & mask;
         h2_in.lane[j].tx  = h1_ff.lane[j].tx;
         h2_in.lane[j].ty  = h1_ff.lane[j].ty;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
         h2_valid_ff <= 1'b0;
      end else begin
         h1_valid_ff <= h1_valid_in;
         h2_valid_ff <= h2_valid_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (h1_ready && in_valid) begin
         h1_ff <= h1_in;
      end
      if (h2_ready && h1_valid_ff) begin
         h2_ff <= h2_in;
      end
   end

   assign out_valid = h2_valid_ff;
   assign out_set   = h2_ff;

   // Finest-lane check: a scale-two corner hash keeps one bit.
   a_scale_two_hash_bits : assert property (@(posedge clock) disable iff (reset)
      h2_valid_ff |-> (h2_ff.lane[0].c00[HB-1:1] == '0 && h2_ff.lane[0].c11[HB-1:1] == '0))
      else $error("scale-two hash wider than one bit");

   // A held second stage keeps its item while the consumer stalls.
   a_h2_hold : assert property (@(posedge clock) disable iff (reset)
      h2_valid_ff && !out_ready |=> h2_valid_ff && $stable(h2_ff))
      else $error("hash stage item lost under stall");

endmodule

/* hw/rtl/vno_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vno_blend: bilinear corner blend, two register stages
// The first stage blends along x on both rows of every octave, the second
// blends the two rows along y.
// ----------------------------------------------------------------------------
module vno_blend
   import vno_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  corner_set_type in_set,
   output logic           out_valid,
   input  logic           out_ready,
   output noise_set_type  out_set
);

   logic          b1_valid_ff, b1_valid_in;
   row_set_type   b1_ff, b1_in;
   logic          b1_ready;
   logic          b2_valid_ff, b2_valid_in;
   noise_set_type b2_ff, b2_in;
   logic          b2_ready;

   // Per-stage flow control.
   assign b2_ready = !b2_valid_ff || out_ready;
   assign b1_ready = !b1_valid_ff || b2_ready;
   assign in_ready = b1_ready;

   assign b1_valid_in = b1_ready ? in_valid : b1_valid_ff;
   assign b2_valid_in = b2_ready ? b1_valid_ff : b2_valid_ff;

   // Stage one: x blend of the top and bottom corner pairs.
   always_comb begin
      b1_in.base    = in_set.base;
      b1_in.lane_en = in_set.lane_en;
      for (int j = 0; j < NUM_LANES; j++) begin
         b1_in.lane[j].row0 = lerp(in_set.lane[j].c00, in_set.lane[j].c10,
                                   in_set.lane[j].tx, j + 1);
         b1_in.lane[j].row1 = lerp(in_set.lane[j].c01, in_set.lane[j].c11,
                                   in_set.lane[j].tx, j + 1);
         b1_in.lane[j].ty   = in_set.lane[j].ty;
      end
   end

   // Stage two: y blend of the two rows.
   always_comb begin
      b2_in.base    = b1_ff.base;
      b2_in.lane_en = b1_ff.lane_en;
      for (int j = 0; j < NUM_LANES; j++) begin
         b2_in.v[j] = lerp(b1_ff.lane[j].row0, b1_ff.lane[j].row1,
                           b1_ff.lane[j].ty, j + 1);
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= b1_valid_in;
         b2_valid_ff <= b2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (b1_ready && in_valid) begin
         b1_ff <= b1_in;
      end
      if (b2_ready && b1_valid_ff) begin
         b2_ff <= b2_in;
      end
   end

   assign out_valid = b2_valid_ff;
   assign out_set   = b2_ff;

   // A blend never leaves the span of its corners, so scale two gives 0 or 1.
   a_scale_two_value : assert property (@(posedge clock) disable iff (reset)
      b2_valid_ff |-> b2_ff.v[0][HB-1:1] == '0)
      else $error("scale-two noise value out of range");

endmodule

/* hw/rtl/value_noise_octave_pixel.sv */
`timescale 1ns / 1ps
// Pipeline: an accepted request passes the input, hash, blend and output sum registers in order.
// Throughput: one pixel per cycle unless rsp_tready stalls; six register stages (input, two hash, two
// blend, output sum), each with its own valid bit and per-stage ready.
// Reset: synchronous; clears all valid bits and loads start_octave = 6 and
// hash_seed = 9. No clearing pass: requests are taken on the cycle after reset.
// ----------------------------------------------------------------------------
// value_noise_octave_pixel: fractal value noise added to one frame byte
// Sums bilinear value-noise octaves for scales 2^start_octave down to 1 and
// adds the sum to the incoming byte, modulo 256.
// ----------------------------------------------------------------------------
module value_noise_octave_pixel
   import vno_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pixel_x[8:0], pixel_y[16:9], base_value[24:17]
   // Result stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pixel_value[7:0]
   // Register write port.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SEED_W-1:0]     csr_wdata
);

   logic [OCT_W-1:0]  start_octave_ff;
   logic [HB-1:0]     seed_mix_ff;
   logic [OCT_W-1:0]  top_octave;

   logic              s0_valid_ff, s0_valid_in;
   pix_type           s0_ff, s0_in;
   logic              s0_ready;

   logic              hash_in_ready;
   logic              hash_out_valid;
   corner_set_type    hash_out_set;
   logic              blend_in_ready;
   logic              blend_out_valid;
   noise_set_type     blend_out_set;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_ready;

   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic              req_xfer, rsp_xfer;

   // Register writes. Only the low hash bits of the seed matter, so the seed
   // is stored already multiplied by the hash constant.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_octave_ff <= START_OCTAVE_RST;
         seed_mix_ff     <= mul_mod(HASH_SEED_RST[HB-1:0], HASH_MUL_LO);
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_OCTAVE: start_octave_ff <= csr_wdata[OCT_W-1:0];
            CSR_HASH_SEED:    seed_mix_ff     <= mul_mod(csr_wdata[HB-1:0], HASH_MUL_LO);
            default: ;
         endcase
      end
   end

   // Octaves above the maximum saturate.
   assign top_octave = (start_octave_ff > OCT_W'(MAX_OCTAVE)) ? OCT_W'(MAX_OCTAVE)
                                                               : start_octave_ff;

   // Input stage: unpack, frame check and octave enables.
   always_comb begin
      logic in_frame;
      s0_in.x    = req_tdata[PX_W-1:0];
      s0_in.y    = req_tdata[PX_W+PY_W-1:PX_W];
      s0_in.base = req_tdata[PX_W+PY_W+BYTE_W-1:PX_W+PY_W];
      in_frame   = (s0_in.x < PX_W'(X_SIZE)) && (s0_in.y < PY_W'(Y_SIZE));
      for (int j = 0; j < NUM_LANES; j++) begin
         s0_in.lane_en[j] = in_frame && (OCT_W'(j + 1) <= top_octave);
      end
   end

   assign s0_ready    = !s0_valid_ff || hash_in_ready;
   assign req_tready  = s0_ready;
   assign s0_valid_in = s0_ready ? req_tvalid : s0_valid_ff;

   always_ff @(posedge clock) begin
      if (s0_ready && req_tvalid) begin
         s0_ff <= s0_in;
      end
   end

   vno_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (hash_in_ready),
      .in_pix    (s0_ff),
      .seed_mix  (seed_mix_ff),
      .out_valid (hash_out_valid),
      .out_ready (blend_in_ready),
      .out_set   (hash_out_set)
   );

   vno_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hash_out_valid),
      .in_ready  (blend_in_ready),
      .in_set    (hash_out_set),
      .out_valid (blend_out_valid),
      .out_ready (rsp_ready),
      .out_set   (blend_out_set)
   );

   // Output stage: add the enabled octaves onto the base byte.
   always_comb begin
      rsp_data_in = blend_out_set.base;
      for (int j = 0; j < NUM_LANES; j++) begin
         if (blend_out_set.lane_en[j]) begin
            rsp_data_in = rsp_data_in + BYTE_W'(blend_out_set.v[j]);
         end
      end
   end

   assign rsp_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = rsp_ready ? blend_out_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (rsp_ready && blend_out_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // Items in flight, used by the checks below.
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      case ({req_xfer, rsp_xfer})
         2'b10:   occ_in = occ_ff + OCC_W'(1);
         2'b01:   occ_in = occ_ff - OCC_W'(1);
         default: occ_in = occ_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
      end
   end

   // The pipeline never holds more items than it has stages.
   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

   // A result is only offered for an item that was taken in.
   a_no_invented : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ_ff != '0)
      else $error("result offered with no item in flight");

   // With the output register empty, every stage can move, so input is open.
   a_open_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side stalled while the output is empty");

endmodule
